>>> hdl/lpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page table package
// Field widths, transaction structs and the shared control types used by the
// page table lookup cells, its controller and its checker.
// ----------------------------------------------------------------------------
package lpt_pkg;

  localparam int PAGE_BITS  = 20;
  localparam int FRAME_BITS = 10;
  localparam int COUNT_BITS = 32;

  typedef logic [PAGE_BITS-1:0]  page_t;
  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Input transaction.
  typedef struct packed {
    page_t  page_number;
    frame_t new_frame;
  } lpt_in_t;

  // Result transaction.
  typedef struct packed {
    frame_t frame;
    logic   fault;
    count_t fault_count;
    logic   evicted;
    page_t  evicted_page;
  } lpt_out_t;

  // Accumulated search result handed from cell to cell.
  typedef struct packed {
    logic   hit;
    frame_t frame;
    page_t  victim_page;
  } lpt_scan_t;

  // Update command broadcast to every cell at the end of a search.
  typedef struct packed {
    logic   do_hit;
    logic   do_fill;
    logic   do_evict;
    page_t  page;
    frame_t frame;
  } lpt_upd_t;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } lpt_state_t;

endpackage

>>> hdl/lpt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page table cell
// Holds one table entry with its recency rank, adds its own compare result to
// the search passed along the chain, and applies the broadcast update.
// ----------------------------------------------------------------------------
module lpt_cell #(
  parameter int ENTRIES = 4,
  parameter int IDX     = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lpt_pkg::page_t                 query_page,
  input  lpt_pkg::lpt_scan_t             scan_in,
  input  logic [$clog2(ENTRIES)-1:0]     rank_in,
  output lpt_pkg::lpt_scan_t             scan_out,
  output logic [$clog2(ENTRIES)-1:0]     rank_out,
  input  lpt_pkg::lpt_upd_t              upd,
  input  logic [$clog2(ENTRIES)-1:0]     upd_rank,
  input  logic [$clog2(ENTRIES+1)-1:0]   fill_idx
);
  import lpt_pkg::*;

  localparam int RANK_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  logic              valid_r, valid_nxt;
  page_t             page_r, page_nxt;
  frame_t            frame_r, frame_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  lpt_scan_t         scan_r, scan_nxt;
  logic [RANK_W-1:0] acc_rank_r, acc_rank_nxt;

  logic match;
  logic is_lru;

  assign match  = valid_r && (page_r == query_page);
  assign is_lru = valid_r && (rank_r == RANK_W'(ENTRIES - 1));

  // Add this entry's contribution to the search; entries are unique, so OR works.
  always_comb begin
    scan_nxt.hit         = scan_in.hit | match;
    scan_nxt.frame       = scan_in.frame | (match ? frame_r : '0);
    scan_nxt.victim_page = scan_in.victim_page | (is_lru ? page_r : '0);
    acc_rank_nxt         = rank_in | (match ? rank_r : '0);
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    acc_rank_r <= acc_rank_nxt;
  end

  assign scan_out = scan_r;
  assign rank_out = acc_rank_r;

  // Entry update: the touched, filled or replaced entry becomes most recent;
  // on a hit the younger entries age by one step, else all other valid ones do.
  always_comb begin
    valid_nxt = valid_r;
    page_nxt  = page_r;
    frame_nxt = frame_r;
    rank_nxt  = rank_r;
    if (upd.do_hit) begin
      if (valid_r && (rank_r == upd_rank)) begin
        rank_nxt = '0;
      end else if (valid_r && (rank_r < upd_rank)) begin
        rank_nxt = rank_r + RANK_W'(1);
      end
    end else if (upd.do_fill) begin
      if (CNT_W'(IDX) == fill_idx) begin
        valid_nxt = 1'b1;
        page_nxt  = upd.page;
        frame_nxt = upd.frame;
        rank_nxt  = '0;
      end else if (valid_r) begin
        rank_nxt = rank_r + RANK_W'(1);
      end
    end else if (upd.do_evict) begin
      if (is_lru) begin
        page_nxt  = upd.page;
        frame_nxt = upd.frame;
        rank_nxt  = '0;
      end else if (valid_r) begin
        rank_nxt = rank_r + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r  <= page_nxt;
    frame_r <= frame_nxt;
  end

endmodule

>>> hdl/lpt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page table controller
// Takes one transaction at a time, times the search along the cell chain,
// issues the update, counts faults and holds the result register.
// ----------------------------------------------------------------------------
module lpt_ctrl #(
  parameter int ENTRIES = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lpt_pkg::lpt_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lpt_pkg::lpt_out_t              out_data,
  output lpt_pkg::page_t                 query_page,
  input  lpt_pkg::lpt_scan_t             scan_last,
  input  logic [$clog2(ENTRIES)-1:0]     rank_last,
  output lpt_pkg::lpt_upd_t              upd,
  output logic [$clog2(ENTRIES)-1:0]     upd_rank,
  output logic [$clog2(ENTRIES+1)-1:0]   fill_idx
);
  import lpt_pkg::*;

  localparam int RANK_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  lpt_state_t        state_r, state_nxt;
  logic [RANK_W-1:0] cnt_r, cnt_nxt;
  lpt_in_t           req_r, req_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  count_t            faults_r, faults_nxt;
  logic              out_valid_r, out_valid_nxt;
  lpt_out_t          out_data_r, out_data_nxt;

  logic in_fire;
  logic upd_fire;
  logic full;
  logic miss;

  assign in_fire  = in_valid && !in_stall;
  assign upd_fire = (state_r == ST_UPDATE) && (!out_valid_r || !out_stall);
  assign full     = (fill_r == CNT_W'(ENTRIES));
  assign miss     = !scan_last.hit;

  // Sequencing of one transaction: accept, search, update.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + RANK_W'(1);
        if (cnt_r == RANK_W'(ENTRIES - 1)) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Request register, fill count and saturating fault counter.
  always_comb begin
    req_nxt    = in_fire ? in_data : req_r;
    fill_nxt   = fill_r;
    faults_nxt = faults_r;
    if (upd_fire && miss) begin
      if (!full) begin
        fill_nxt = fill_r + CNT_W'(1);
      end
      if (faults_r != '1) begin
        faults_nxt = faults_r + COUNT_BITS'(1);
      end
    end
  end

  // Update command to the cells.
  always_comb begin
    upd.do_hit   = upd_fire && !miss;
    upd.do_fill  = upd_fire && miss && !full;
    upd.do_evict = upd_fire && miss && full;
    upd.page     = req_r.page_number;
    upd.frame    = req_r.new_frame;
  end

  // Result register: loaded at the update, released when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (upd_fire) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.frame        = miss ? req_r.new_frame : scan_last.frame;
      out_data_nxt.fault        = miss;
      out_data_nxt.fault_count  = faults_nxt;
      out_data_nxt.evicted      = miss && full;
      out_data_nxt.evicted_page = (miss && full) ? scan_last.victim_page : '0;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      faults_r    <= faults_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign query_page = req_r.page_number;
  assign upd_rank   = rank_last;
  assign fill_idx   = fill_r;

endmodule

>>> hdl/lru_page_table_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page table lookup
// Fully associative page table with least-recently-used replacement, built
// as a chain of entry cells behind a small controller.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time: it accepts it, lets the search
// ripple through the registered chain of entry cells, then updates the table
// and loads the result register. The update waits for as long as an earlier
// result is still held in the output register, so receiver stalls lengthen
// a transaction for as long as the earlier result stays stalled. The next
// transaction is accepted while the previous result still waits in the
// output register. Faults are counted in 32 bits and the count saturates at
// its maximum. After reset the table is empty and ready at once.
// ----------------------------------------------------------------------------
module lru_page_table_lookup #(
  parameter int ENTRIES = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lpt_pkg::lpt_in_t     in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lpt_pkg::lpt_out_t    out_data
);
  import lpt_pkg::*;

  localparam int RANK_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  page_t             query_page;
  lpt_upd_t          upd;
  logic [RANK_W-1:0] upd_rank;
  logic [CNT_W-1:0]  fill_idx;
  lpt_scan_t         scan_chain [ENTRIES+1];
  logic [RANK_W-1:0] rank_chain [ENTRIES+1];

  // The search enters the chain empty.
  assign scan_chain[0] = '0;
  assign rank_chain[0] = '0;

  lpt_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .query_page (query_page),
    .scan_last  (scan_chain[ENTRIES]),
    .rank_last  (rank_chain[ENTRIES]),
    .upd        (upd),
    .upd_rank   (upd_rank),
    .fill_idx   (fill_idx)
  );

  // One cell per table entry, each feeding its neighbour.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lpt_cell #(
      .ENTRIES (ENTRIES),
      .IDX     (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .query_page (query_page),
      .scan_in    (scan_chain[g]),
      .rank_in    (rank_chain[g]),
      .scan_out   (scan_chain[g+1]),
      .rank_out   (rank_chain[g+1]),
      .upd        (upd),
      .upd_rank   (upd_rank),
      .fill_idx   (fill_idx)
    );
  end

endmodule

>>> hdl/lpt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page table checker
// Watches the ports of the page table lookup and flags behaviour that the
// design must never show.
// ----------------------------------------------------------------------------
module lpt_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  lpt_pkg::lpt_in_t     in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  lpt_pkg::lpt_out_t    out_data
);
  import lpt_pkg::*;

  // Only one transaction is in flight, so an accepted one blocks the next.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("lpt: input accepted while a transaction is in flight");

  // An eviction only happens on a fault.
  a_evict_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.evicted |-> out_data.fault)
    else $error("lpt: eviction reported without a fault");

  // The evicted page reads zero when nothing was evicted.
  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.evicted |-> out_data.evicted_page == '0)
    else $error("lpt: evicted page not zero without eviction");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("lpt: stalled result changed");

endmodule

bind lru_page_table_lookup lpt_checker u_lpt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> bench/lru_page_table_lookup_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page table lookup checker
// Watches both channels of the page table. It keeps its own copy of the
// table, computes the translation that each accepted lookup must produce, and
// compares every accepted result with the oldest translation still due.
// ----------------------------------------------------------------------------
module lru_page_table_lookup_checker #(
  parameter int ENTRIES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  lpt_pkg::lpt_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  lpt_pkg::lpt_out_t out_data,
  output int                fail_count,
  output int                pending
);

  import lpt_pkg::*;

  localparam int RANK_BITS = $clog2(ENTRIES);
  typedef logic [RANK_BITS-1:0] rank_t;

  // Shadow copy of the table. Rank 0 is the most recent entry.
  logic   tbl_valid [ENTRIES];
  page_t  tbl_page  [ENTRIES];
  frame_t tbl_frame [ENTRIES];
  rank_t  tbl_rank  [ENTRIES];
  count_t faults_seen;

  lpt_out_t translations_due[$];
  int       errors;

  // Ages valid entries by one step: all of them, or those younger than limit.
  function automatic void age_entries(input logic every, input rank_t limit);
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i] && (every || tbl_rank[i] < limit)) begin
        tbl_rank[i] = tbl_rank[i] + 1'b1;
      end
    end
  endfunction

  // Looks one page up in the shadow table, updates it and returns the result.
  function automatic lpt_out_t translate_page(input lpt_in_t txn);
    lpt_out_t res;
    int       hit_idx;
    int       slot;
    res     = '0;
    hit_idx = -1;
    slot    = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_idx < 0 && tbl_valid[i] && tbl_page[i] == txn.page_number) begin
        hit_idx = i;
      end
    end
    if (hit_idx >= 0) begin
      age_entries(1'b0, tbl_rank[hit_idx]);
      tbl_rank[hit_idx] = '0;
      res.frame = tbl_frame[hit_idx];
    end else begin
      res.fault = 1'b1;
      if (faults_seen != '1) begin
        faults_seen = faults_seen + 1'b1;
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && !tbl_valid[i]) begin
          slot = i;
        end
      end
      if (slot >= 0) begin
        // A free entry is taken, so every entry already held gets older.
        age_entries(1'b1, '0);
      end else begin
        // Table full: the oldest entry goes, the lowest index on a tie.
        slot = 0;
        for (int i = 1; i < ENTRIES; i++) begin
          if (tbl_rank[i] > tbl_rank[slot]) begin
            slot = i;
          end
        end
        res.evicted      = 1'b1;
        res.evicted_page = tbl_page[slot];
        age_entries(1'b0, tbl_rank[slot]);
      end
      tbl_valid[slot] = 1'b1;
      tbl_page[slot]  = txn.page_number;
      tbl_frame[slot] = txn.new_frame;
      tbl_rank[slot]  = '0;
      res.frame       = txn.new_frame;
    end
    res.fault_count = faults_seen;
    return res;
  endfunction

  task automatic report_field(input string field, input longint unsigned want,
                              input longint unsigned got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    errors++;
  endtask

  // Predict on every accepted lookup, compare on every accepted result.
  always @(posedge clk) begin
    lpt_out_t want;
    lpt_out_t got;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tbl_valid[i] = 1'b0;
        tbl_page[i]  = '0;
        tbl_frame[i] = '0;
        tbl_rank[i]  = '0;
      end
      faults_seen = '0;
      translations_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        translations_due.push_back(translate_page(in_data));
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (translations_due.size() == 0) begin
          $display("%0t: result transaction with none expected, got 0x%0h", $time, got);
          errors++;
        end else begin
          want = translations_due.pop_front();
          if (got.frame !== want.frame)
            report_field("frame", want.frame, got.frame);
          if (got.fault !== want.fault)
            report_field("fault", want.fault, got.fault);
          if (got.fault_count !== want.fault_count)
            report_field("fault_count", want.fault_count, got.fault_count);
          if (got.evicted !== want.evicted)
            report_field("evicted", want.evicted, got.evicted);
          if (got.evicted_page !== want.evicted_page)
            report_field("evicted_page", want.evicted_page, got.evicted_page);
        end
      end
    end
    pending    <= translations_due.size();
    fail_count <= errors;
  end

endmodule

>>> bench/lru_page_table_lookup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page table lookup testbench
// Drives a short directed run through fills, hits and evictions, then random
// lookups drawn mostly from small page sets so that hits and replacements
// are frequent. Sender bursts and receiver stalls vary throughout; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module lru_page_table_lookup_tb;

  import lpt_pkg::*;

  localparam int ENTRIES        = 4;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 4 * (ENTRIES + 2);

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  lpt_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  lpt_out_t out_data;

  int fail_count;
  int pending;
  int lookups_sent = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;

  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  lru_page_table_lookup #(.ENTRIES(ENTRIES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  lru_page_table_lookup_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver stalls follow a mode that is redrawn at random times.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
      default:        out_stall <= ((stall_left % 7) < 3);
    endcase
  end

  // Ends the run if neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("lru_page_table_lookup test failed");
      $finish;
    end
  end

  // Presents one lookup until it is taken, then perhaps pauses between bursts.
  task automatic issue(input page_t page, input frame_t frame);
    lpt_in_t item;
    int      gap;
    item.page_number = page;
    item.new_frame   = frame;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    lookups_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  initial begin : stimulus
    page_t pool [8];
    int    pool_size;
    int    run_len;
    page_t page;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Page zero must miss: empty entries are not valid after reset, whatever page they hold.
    issue(20'h00000, 10'h000);
    issue(20'h00000, 10'h3FF);
    issue(20'hFFFFF, 10'h3FF);
    issue(20'h00001, 10'h155);
    issue(20'h80000, 10'h2AA);
    // Table is full from here: hits on middle, newest and oldest entries.
    issue(20'hFFFFF, 10'h000);
    issue(20'h80000, 10'h001);
    issue(20'h80000, 10'h002);
    issue(20'h00000, 10'h0F0);
    // Misses on a full table evict the least recent page each time; the last two hit.
    issue(20'h7FFFF, 10'h30C);
    issue(20'h00001, 10'h0C3);
    issue(20'hFFFFF, 10'h3FF);
    issue(20'h80000, 10'h000);
    issue(20'h00000, 10'h200);
    issue(20'hAAAAA, 10'h155);
    issue(20'h55555, 10'h2AA);
    issue(20'hAAAAA, 10'h001);
    issue(20'h00000, 10'h3FE);

    // Random lookups: small page sets to keep hits and evictions frequent.
    while (lookups_sent < 18 + RANDOM_ITEMS) begin
      pool_size = $urandom_range(2, 7);
      for (int k = 0; k < pool_size; k++) begin
        case ($urandom_range(0, 5))
          0:       pool[k] = '0;
          1:       pool[k] = '1;
          2:       pool[k] = pool[0] ^ (page_t'(1) << $urandom_range(0, PAGE_BITS - 1));
          default: pool[k] = page_t'($urandom());
        endcase
      end
      run_len = $urandom_range(30, 200);
      repeat (run_len) begin
        if ($urandom_range(0, 9) == 0) begin
          page = page_t'($urandom());
        end else begin
          page = pool[$urandom_range(0, pool_size - 1)];
        end
        issue(page, frame_t'($urandom()));
      end
    end
    in_valid <= 1'b0;

    // The outstanding count is registered, so let it settle after the last lookup is taken.
    @(posedge clk);
    // Drain the outstanding results, then allow for anything spurious.
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("lru_page_table_lookup test passed");
    end else begin
      $display("lru_page_table_lookup test failed");
    end
    $finish;
  end

endmodule
